@@ rtl/modinv_pkg.sv @@
// ----------------------------------------------------------------------------
// modinv_pkg: shared types and constants for the modular inverse block
// Port widths of the operand and result fields, and the status bundle that
// the divide/accumulate unit hands back to the sequencer.
// ----------------------------------------------------------------------------
package modinv_pkg;

    // Fixed widths of the operand and result ports
    localparam int IN_WIDTH  = 32;
    localparam int OUT_WIDTH = 32;

    // Status of the shared divide/accumulate unit
    typedef struct packed {
        logic busy;
        logic done;
    } modinv_step_stat_t;

endpackage

@@ rtl/modinv_divacc.sv @@
// ----------------------------------------------------------------------------
// modinv_divacc: shared bit-serial divide and multiply-accumulate unit
// Restoring division, one quotient bit per cycle, MSB first. Each quotient bit
// also feeds a Horner accumulator, so that acc ends as quotient * mult_in.
// ----------------------------------------------------------------------------
module modinv_divacc
    import modinv_pkg::*;
#(
    parameter int W = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [W-1:0]      dividend,
    input  logic [W-1:0]      divisor,
    input  logic [W-1:0]      mult_in,
    output logic [W-1:0]      remainder,
    output logic [W-1:0]      product,
    output modinv_step_stat_t stat
);

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     dvd_reg, dvd_next;
    logic [W-1:0]     acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [W:0] shifted;
    logic [W:0] diff;
    logic       qbit;

    assign shifted = {rem_reg, dvd_reg[W-1]};
    assign diff    = shifted - {1'b0, divisor};
    assign qbit    = (shifted >= {1'b0, divisor});

    always_comb begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            dvd_next  = dividend;
            acc_next  = '0;
            cnt_next  = CNT_W'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // one quotient bit; partial product never exceeds the final one
            rem_next = qbit ? diff[W-1:0] : shifted[W-1:0];
            dvd_next = {dvd_reg[W-2:0], 1'b0};
            acc_next = {acc_reg[W-2:0], 1'b0} + (qbit ? mult_in : '0);
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        acc_reg <= acc_next;
    end

    assign remainder = rem_reg;
    assign product   = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ rtl/modular_inverse_ext_euclid.sv @@
// Latency: equal or zero operands skip the Euclid loop and go straight to the output
//   state; otherwise the sequencer runs one divider pass per Euclid round (at most
//   about 46 rounds for 32-bit operands).
// Throughput: one item at a time; the bit-serial divider sets the round length.
// Reset: synchronous, active low; clears the sequencer and the result valid flag.
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid: modular inverse by extended Euclid
// The larger operand is the modulus; the smaller is inverted modulo it. A
// small sequencer drives one shared bit-serial divide/accumulate unit through
// each Euclid round and then normalizes the Bezout coefficient.
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid
    import modinv_pkg::*;
#(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [IN_WIDTH-1:0]  s_first_number,
    input  logic [IN_WIDTH-1:0]  s_second_number,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [OUT_WIDTH-1:0] m_inverse_value,
    output logic                 m_inverse_exists
);

    localparam int W = OPERAND_WIDTH;

    // One-hot sequencer states
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,   // wait for an input transfer
        ST_TEST = 5'b00010,   // end of Euclid loop check, kick the divider
        ST_DIV  = 5'b00100,   // divider running; fold its result in on done
        ST_NORM = 5'b01000,   // gcd test and sign normalization
        ST_OUT  = 5'b10000    // hand the result to the output register
    } state_t;

    state_t state_reg, state_next;

    // Euclid working set: remainders, coefficient magnitudes and their signs
    logic [W-1:0] r_prev_reg, r_prev_next;
    logic [W-1:0] r_cur_reg,  r_cur_next;
    logic [W-1:0] t_prev_reg, t_prev_next;
    logic [W-1:0] t_cur_reg,  t_cur_next;
    logic         neg_prev_reg, neg_prev_next;
    logic         neg_cur_reg,  neg_cur_next;
    logic [W-1:0] mod_reg,    mod_next;

    // Finished result, waiting for the output register
    logic [W-1:0] res_val_reg, res_val_next;
    logic         res_ok_reg,  res_ok_next;

    // Output register
    logic                 m_valid_reg, m_valid_next;
    logic [OUT_WIDTH-1:0] out_val_reg, out_val_next;
    logic                 out_ok_reg,  out_ok_next;

    logic [W-1:0] a_op, b_op, large_op, small_op;
    logic [W-1:0] t_norm;
    logic [OUT_WIDTH-1:0] res_val_out;
    logic         out_load;

    logic              div_start;
    logic [W-1:0]      div_rem, div_prod;
    modinv_step_stat_t div_stat;

    // Take the low OPERAND_WIDTH bits of each operand (zero-extended if wider), and fit the result to OUT_WIDTH
    generate
        if (W <= IN_WIDTH) begin : g_op_trunc
            assign a_op = s_first_number[W-1:0];
            assign b_op = s_second_number[W-1:0];
        end else begin : g_op_ext
            assign a_op = {{(W-IN_WIDTH){1'b0}}, s_first_number};
            assign b_op = {{(W-IN_WIDTH){1'b0}}, s_second_number};
        end
        if (W >= OUT_WIDTH) begin : g_res_trunc
            assign res_val_out = res_val_reg[OUT_WIDTH-1:0];
        end else begin : g_res_ext
            assign res_val_out = {{(OUT_WIDTH-W){1'b0}}, res_val_reg};
        end
    endgenerate

    assign large_op = (a_op > b_op) ? a_op : b_op;
    assign small_op = (a_op > b_op) ? b_op : a_op;

    // A coefficient equal to the modulus reduces to zero
    assign t_norm = (t_prev_reg == mod_reg) ? '0 : t_prev_reg;

    assign s_ready   = (state_reg == ST_IDLE);
    assign div_start = (state_reg == ST_TEST) && (r_cur_reg != '0);
    // Load the output register when it is empty or being drained this cycle
    assign out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    modinv_divacc #(
        .W (W)
    ) u_divacc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (r_prev_reg),
        .divisor   (r_cur_reg),
        .mult_in   (t_cur_reg),
        .remainder (div_rem),
        .product   (div_prod),
        .stat      (div_stat)
    );

    always_comb begin
        state_next    = state_reg;
        r_prev_next   = r_prev_reg;
        r_cur_next    = r_cur_reg;
        t_prev_next   = t_prev_reg;
        t_cur_next    = t_cur_reg;
        neg_prev_next = neg_prev_reg;
        neg_cur_next  = neg_cur_reg;
        mod_next      = mod_reg;
        res_val_next  = res_val_reg;
        res_ok_next   = res_ok_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    r_prev_next   = large_op;
                    r_cur_next    = small_op;
                    mod_next      = large_op;
                    t_prev_next   = '0;
                    t_cur_next    = {{(W-1){1'b0}}, 1'b1};
                    neg_prev_next = 1'b0;
                    neg_cur_next  = 1'b0;
                    res_val_next  = '0;
                    if (a_op == b_op) begin
                        // equal operands: only one and one counts, with value zero
                        res_ok_next = (a_op == {{(W-1){1'b0}}, 1'b1});
                        state_next  = ST_OUT;
                    end else if (small_op == '0) begin
                        res_ok_next = 1'b0;
                        state_next  = ST_OUT;
                    end else begin
                        state_next = ST_TEST;
                    end
                end
            end
            ST_TEST: begin
                // a zero remainder ends the loop; otherwise the divider starts
                state_next = (r_cur_reg == '0) ? ST_NORM : ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    // advance one round: t_next = t_prev + q * t_cur
                    r_prev_next   = r_cur_reg;
                    r_cur_next    = div_rem;
                    t_prev_next   = t_cur_reg;
                    t_cur_next    = div_prod + t_prev_reg;
                    neg_prev_next = neg_cur_reg;
                    neg_cur_next  = !neg_cur_reg;
                    state_next    = ST_TEST;
                end
            end
            ST_NORM: begin
                res_ok_next = (r_prev_reg == {{(W-1){1'b0}}, 1'b1});
                if (r_prev_reg != {{(W-1){1'b0}}, 1'b1}) begin
                    res_val_next = '0;
                end else if (neg_prev_reg && (t_norm != '0)) begin
                    res_val_next = mod_reg - t_norm;
                end else begin
                    res_val_next = t_norm;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: hold until transfer, reload behind a draining result
    always_comb begin
        m_valid_next = m_valid_reg;
        out_val_next = out_val_reg;
        out_ok_next  = out_ok_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
            out_val_next = res_val_out;
            out_ok_next  = res_ok_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        r_prev_reg   <= r_prev_next;
        r_cur_reg    <= r_cur_next;
        t_prev_reg   <= t_prev_next;
        t_cur_reg    <= t_cur_next;
        neg_prev_reg <= neg_prev_next;
        neg_cur_reg  <= neg_cur_next;
        mod_reg      <= mod_next;
        res_val_reg  <= res_val_next;
        res_ok_reg   <= res_ok_next;
        out_val_reg  <= out_val_next;
        out_ok_reg   <= out_ok_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_inverse_value  = out_val_reg;
    assign m_inverse_exists = out_ok_reg;

endmodule

@@ rtl/modinv_checker.sv @@
// ----------------------------------------------------------------------------
// modinv_checker: port-level checks for the modular inverse block
// Watches the handshakes and result fields over time; bound to the top level.
// ----------------------------------------------------------------------------
module modinv_checker
    import modinv_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic [IN_WIDTH-1:0]  s_first_number,
    input logic [IN_WIDTH-1:0]  s_second_number,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [OUT_WIDTH-1:0] m_inverse_value,
    input logic                 m_inverse_exists
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_inverse_value)
            && $stable(m_inverse_exists))
        else $error("result changed while stalled");

    // No inverse means a zero value
    a_no_inv_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_inverse_exists |-> m_inverse_value == '0)
        else $error("nonzero value without an inverse");

    // One item at a time: input closes after a transfer
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input still open after transfer");

    // Reset leaves no result pending
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind modular_inverse_ext_euclid modinv_checker u_modinv_checker (.*);

@@ sim/tb_modular_inverse_ext_euclid.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modular_inverse_ext_euclid: self-checking bench for the modular inverse
// Walks a table of directed operand pairs, then several hundred random pairs
// under varying sender gaps and receiver stalls. Each result is compared with a
// hand-typed expectation or an in-bench extended Euclid calculation of the inverse.
// ----------------------------------------------------------------------------
module tb_modular_inverse_ext_euclid;
    import modinv_pkg::*;

    localparam int OPERAND_WIDTH  = 32;
    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 12;
    localparam int ITEMS_PER_PASS = 100;
    localparam int NUM_PASSES     = 4;
    // Receiver hold-off; long enough for the block to fill and stall its input
    localparam int HOLD_CYCLES    = 3000;
    // Worst case is about 46 Euclid rounds per item
    localparam int TAIL_CYCLES    = 2000;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int MAX_REPORTS    = 10;
    localparam longint unsigned OPND_MASK = (64'd1 << OPERAND_WIDTH) - 1;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] inverse;
        logic                 exists;
    } inv_result_t;

    // One outstanding result, with its operands kept for reporting
    typedef struct {
        logic [IN_WIDTH-1:0] first;
        logic [IN_WIDTH-1:0] second;
        inv_result_t         res;
    } inv_pending_t;

    // Directed table row; typed rows carry an expected result read off by hand
    typedef struct {
        logic [IN_WIDTH-1:0] first;
        logic [IN_WIDTH-1:0] second;
        bit                  typed;
        inv_result_t         res;
    } stim_row_t;

    localparam int NUM_DIRECTED = 21;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [IN_WIDTH-1:0]  s_first_number = '0;
    logic [IN_WIDTH-1:0]  s_second_number = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [OUT_WIDTH-1:0] m_inverse_value;
    logic                 m_inverse_exists;

    inv_pending_t pending_inverses[$];
    stim_row_t    directed_rows[NUM_DIRECTED];
    int           mismatch_count = 0;
    int           quiet_cycles = 0;
    int           sender_idle_pct = 0;
    int           receiver_stall_pct = 0;
    logic         hold_active = 1'b0;
    event         hold_go;

    modular_inverse_ext_euclid #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_first_number  (s_first_number),
        .s_second_number (s_second_number),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_inverse_value (m_inverse_value),
        .m_inverse_exists(m_inverse_exists)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // Extended Euclid on the larger operand as modulus. Coefficients are kept
    // as magnitudes with an alternating sign, so 64-bit math never overflows.
    function automatic inv_result_t predict_inverse(input logic [IN_WIDTH-1:0] x,
                                                    input logic [IN_WIDTH-1:0] y);
        longint unsigned a, b, modulus, value, q;
        longint unsigned r_prev, r_cur, r_next, t_prev, t_cur, t_next;
        bit              prev_neg, cur_neg;
        inv_result_t     res;
        a = longint'(x) & OPND_MASK;
        b = longint'(y) & OPND_MASK;
        modulus = (a > b) ? a : b;
        value = (a > b) ? b : a;
        res = '0;
        if (a == b) begin
            // Equal operands: only 1 and 1 count as invertible, with result 0
            res.exists = (a == 1);
        end else if (value != 0) begin
            r_prev = modulus;
            r_cur = value;
            t_prev = 0;
            t_cur = 1;
            prev_neg = 1'b0;
            cur_neg = 1'b0;
            while (r_cur != 0) begin
                q = r_prev / r_cur;
                r_next = r_prev - q * r_cur;
                t_next = t_prev + q * t_cur;
                r_prev = r_cur;
                r_cur = r_next;
                t_prev = t_cur;
                t_cur = t_next;
                prev_neg = cur_neg;
                cur_neg = !cur_neg;
            end
            // gcd above 1 leaves no inverse and a zero value
            if (r_prev == 1) begin
                t_prev = t_prev % modulus;
                if (prev_neg && t_prev != 0) begin
                    t_prev = modulus - t_prev;
                end
                res.inverse = t_prev[OUT_WIDTH-1:0];
                res.exists = 1'b1;
            end
        end
        return res;
    endfunction

    // Offer one operand pair, hold it until the transfer, then record the
    // result the block owes us.
    task automatic send_operands(input logic [IN_WIDTH-1:0] first,
                                 input logic [IN_WIDTH-1:0] second,
                                 input bit typed, input inv_result_t typed_res);
        inv_pending_t entry;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_first_number <= first;
        s_second_number <= second;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        entry.first = first;
        entry.second = second;
        entry.res = typed ? typed_res : predict_inverse(first, second);
        pending_inverses.push_back(entry);
    endtask

    // Random operand pairs, weighted toward the interesting corners: narrow
    // values, equal pairs, zero and one, exact multiples, consecutive values.
    task automatic pick_operands(output logic [IN_WIDTH-1:0] first,
                                 output logic [IN_WIDTH-1:0] second);
        logic [IN_WIDTH-1:0] mask;
        logic [IN_WIDTH-1:0] swap;
        int                  width;
        first = $urandom();
        second = $urandom();
        case ($urandom_range(0, 9))
            5: begin
                width = $urandom_range(1, IN_WIDTH);
                mask = IN_WIDTH'((64'd1 << width) - 1);
                first &= mask;
                second &= mask;
            end
            6: begin
                if ($urandom_range(0, 1) == 1) begin
                    first = $urandom_range(0, 3);
                end
                second = first;
            end
            7: begin
                second = $urandom_range(0, 1);
            end
            8: begin
                second = $urandom_range(1, 65535);
                first = second * $urandom_range(1, 65535);
            end
            9: begin
                second = first + 1;
            end
            default: begin
            end
        endcase
        if ($urandom_range(0, 1) == 1) begin
            swap = first;
            first = second;
            second = swap;
        end
    endtask

    // Long receiver hold-off, timed in its own process
    always begin
        @(hold_go);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_active <= 1'b0;
    end

    // Drive m_ready and check each result transfer against the oldest entry
    always @(posedge aclk) begin
        inv_pending_t entry;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_inverses.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("unexpected result: inverse %h exists %b",
                                 m_inverse_value, m_inverse_exists);
                    end
                end else begin
                    entry = pending_inverses.pop_front();
                    if (m_inverse_value !== entry.res.inverse
                            || m_inverse_exists !== entry.res.exists) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("mismatch for %h, %h: inverse exp %h got %h, exists exp %b got %b",
                                     entry.first, entry.second, entry.res.inverse,
                                     m_inverse_value, entry.res.exists, m_inverse_exists);
                        end
                    end
                end
            end
            if (hold_active) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
            end
        end
    end

    // Watchdog: give up after too many cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            quiet_cycles <= 0;
        end else if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[modular_inverse_ext_euclid] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [IN_WIDTH-1:0] first;
        logic [IN_WIDTH-1:0] second;

        // Typed rows: zero, equal and divisor cases, and a smaller operand
        // of 1. The rest go through the Euclid calculation above.
        directed_rows = '{
            '{32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0, 1'b0}},
            '{32'h0000_0001, 32'h0000_0001, 1'b1, '{32'h0, 1'b1}},
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b0}},
            '{32'h0000_3039, 32'h0000_3039, 1'b1, '{32'h0, 1'b0}},
            '{32'h0000_0000, 32'h0000_0007, 1'b1, '{32'h0, 1'b0}},
            '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'h0, 1'b0}},
            '{32'h0000_0000, 32'h0000_0001, 1'b1, '{32'h0, 1'b0}},
            '{32'h0000_0001, 32'hFFFF_FFFF, 1'b1, '{32'h1, 1'b1}},
            '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, '{32'h1, 1'b1}},
            '{32'h0000_0001, 32'h0000_0002, 1'b1, '{32'h1, 1'b1}},
            '{32'h0000_0003, 32'h0000_000C, 1'b1, '{32'h0, 1'b0}},
            '{32'hAAAA_AAAA, 32'h5555_5555, 1'b1, '{32'h0, 1'b0}},
            '{32'h0000_000A, 32'h0000_0002, 1'b1, '{32'h0, 1'b0}},
            '{32'h0000_0002, 32'hFFFF_FFFF, 1'b0, '{32'h0, 1'b0}},
            '{32'h0000_0003, 32'h0000_0007, 1'b0, '{32'h0, 1'b0}},
            '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0, '{32'h0, 1'b0}},
            // consecutive Fibonacci numbers: the longest round count
            '{32'd1836311903, 32'd2971215073, 1'b0, '{32'h0, 1'b0}},
            '{32'd2971215073, 32'd1836311903, 1'b0, '{32'h0, 1'b0}},
            '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '{32'h0, 1'b0}},
            '{32'h0000_0006, 32'h0000_0009, 1'b0, '{32'h0, 1'b0}},
            '{32'hDEAD_BEEF, 32'h1234_5678, 1'b0, '{32'h0, 1'b0}}
        };

        // Hold reset, then release it at a clock edge
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            send_operands(directed_rows[i].first, directed_rows[i].second,
                          directed_rows[i].typed, directed_rows[i].res);
        end

        // Random passes: no idling (with one long hold-off), sender gaps,
        // receiver stalls, then both together.
        for (int pass = 0; pass < NUM_PASSES; pass++) begin
            case (pass)
                0: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                    -> hold_go;
                end
                1: begin
                    sender_idle_pct = 58;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 58;
                end
                default: begin
                    sender_idle_pct = 28;
                    receiver_stall_pct = 28;
                end
            endcase
            repeat (ITEMS_PER_PASS) begin
                pick_operands(first, second);
                send_operands(first, second, 1'b0, '0);
            end
        end
        s_valid <= 1'b0;

        // Drain outstanding results, then watch for anything spurious
        while (pending_inverses.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && pending_inverses.size() == 0) begin
            $display("[modular_inverse_ext_euclid] OK");
        end else begin
            $display("[modular_inverse_ext_euclid] ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/modinv_pkg.sv
rtl/modinv_divacc.sv
rtl/modular_inverse_ext_euclid.sv
rtl/modinv_checker.sv
sim/tb_modular_inverse_ext_euclid.sv
